@@ rtl/core/substitution_running_key_shift_cipher_macros.svh @@
// Assertion macros for the substitution running-key shift cipher.
`ifndef SUBSTITUTION_RUNNING_KEY_SHIFT_CIPHER_MACROS_SVH
`define SUBSTITUTION_RUNNING_KEY_SHIFT_CIPHER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define SRKSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srksc: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SRKSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srksc: next-cycle check failed");

`else

`define SRKSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRKSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/srksc_pkg.sv @@
// Shared types, codes and the microcode table of the substitution running-key shift cipher.
package srksc_pkg;

    localparam int KEY_LEN_W = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_STEPS = 9;
    localparam int CNT_W = 4;

    localparam logic [1:0] REQ_ENCRYPT  = 2'd0;
    localparam logic [1:0] REQ_LOAD_MAP = 2'd1;
    localparam logic [1:0] REQ_LOAD_KEY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] map_value;
        logic [9:0] key_slot;
        logic [6:0] key_value;
        logic       last_in;
    } in_payload_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       key_used;
        logic       last_out;
    } out_payload_t;

    typedef logic [2:0] step_t;

    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_DECODE = 3'd1;
    localparam step_t STEP_MAP    = 3'd2;
    localparam step_t STEP_DIV    = 3'd3;
    localparam step_t STEP_EMIT   = 3'd4;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NOT_ENCRYPT,
        COND_OUT_RANGE,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic ld_in;
        logic mem_op;
        logic ld_sub;
        logic div_step;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic not_encrypt;
        logic out_range;
        logic div_busy;
        logic out_full;
    } stat_t;

    typedef struct packed {
        ctl_t  act;
        cond_t wait_on;
        cond_t br_on;
        step_t br_to;
    } uword_t;

    // A step stays put while its wait condition holds, then branches or falls through.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        begin
            w = '{act: '0, wait_on: COND_NEVER, br_on: COND_ALWAYS, br_to: STEP_FETCH};
            unique case (s)
                STEP_FETCH:
                begin
                    w.act.ld_in = 1'b1;
                    w.wait_on   = COND_NO_INPUT;
                    w.br_on     = COND_NEVER;
                end
                STEP_DECODE:
                begin
                    w.act.mem_op = 1'b1;
                    w.br_on      = COND_NOT_ENCRYPT;
                    w.br_to      = STEP_FETCH;
                end
                STEP_MAP:
                begin
                    w.act.ld_sub = 1'b1;
                    w.br_on      = COND_OUT_RANGE;
                    w.br_to      = STEP_EMIT;
                end
                STEP_DIV:
                begin
                    w.act.div_step = 1'b1;
                    w.wait_on      = COND_DIV_BUSY;
                    w.br_on        = COND_NEVER;
                end
                STEP_EMIT:
                begin
                    w.act.emit = 1'b1;
                    w.wait_on  = COND_OUT_FULL;
                    w.br_on    = COND_ALWAYS;
                    w.br_to    = STEP_FETCH;
                end
                default:
                begin
                    w.br_on = COND_ALWAYS;
                    w.br_to = STEP_FETCH;
                end
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/core/srksc_ram.sv @@
// Generic single-port RAM with registered read data.
module srksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[addr];
        end
    end

endmodule

@@ rtl/core/srksc_dp.sv @@
// Datapath of the cipher: configuration, map and key stores, remainder unit and output register.
module srksc_dp #(
    parameter int KEY_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [srksc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [srksc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   in_valid,
    input  srksc_pkg::in_payload_t                 in_data,
    input  srksc_pkg::ctl_t                        ctl,
    output srksc_pkg::stat_t                       stat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output srksc_pkg::out_payload_t                out_data
);

    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LEN_W = ($clog2(KEY_DEPTH + 1) > srksc_pkg::KEY_LEN_W) ?
                           $clog2(KEY_DEPTH + 1) : srksc_pkg::KEY_LEN_W;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(KEY_DEPTH);

    logic [7:0]                     range_low_reg;
    logic [7:0]                     range_high_reg;
    logic [srksc_pkg::KEY_LEN_W-1:0] key_length_reg;
    srksc_pkg::in_payload_t         req_reg;
    logic [255:0]                   loaded_reg;
    logic [KEY_AW-1:0]              key_pos_reg;
    logic [KEY_AW-1:0]              key_pos_next;
    logic [KEY_AW-1:0]              pos_reg;
    logic [7:0]                     c_reg;
    logic                           used_reg;
    logic [8:0]                     div_reg;
    logic [8:0]                     rem_reg;
    logic [8:0]                     rem_next;
    logic [srksc_pkg::CNT_W-1:0]    cnt_reg;
    logic                           out_valid_reg;
    srksc_pkg::out_payload_t        out_data_reg;
    srksc_pkg::out_payload_t        out_data_next;

    logic [LEN_W-1:0]  klen_ext;
    logic [LEN_W-1:0]  eff_len;
    logic [KEY_AW-1:0] pos_sel;
    logic [LEN_W-1:0]  pos_inc;
    logic [KEY_AW-1:0] pos_adv;
    logic [LEN_W-1:0]  slot_ext;
    logic              slot_ok;
    logic              is_map_load;
    logic              is_key_load;
    logic              map_we;
    logic              key_we;
    logic [KEY_AW-1:0] key_addr;
    logic [7:0]        map_rdata;
    logic [6:0]        key_rdata;
    logic [7:0]        c_sel;
    logic              in_rng;
    logic [8:0]        sum_w;
    logic [8:0]        span;
    logic [8:0]        trial;
    logic              out_full;
    logic              fire;

    always_comb
    begin
        klen_ext = LEN_W'(key_length_reg);
        if (key_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (klen_ext > DEPTH_L)
        begin
            eff_len = DEPTH_L;
        end
        else
        begin
            eff_len = klen_ext;
        end
    end

    assign pos_sel  = (LEN_W'(key_pos_reg) < eff_len) ? key_pos_reg : '0;
    assign pos_inc  = LEN_W'(pos_reg) + LEN_W'(1);
    assign pos_adv  = (pos_inc >= eff_len) ? '0 : pos_inc[KEY_AW-1:0];
    assign slot_ext = LEN_W'(req_reg.key_slot);
    assign slot_ok  = slot_ext < DEPTH_L;

    assign is_map_load = req_reg.req_type == srksc_pkg::REQ_LOAD_MAP;
    assign is_key_load = req_reg.req_type == srksc_pkg::REQ_LOAD_KEY;
    assign map_we      = ctl.mem_op && is_map_load;
    assign key_we      = ctl.mem_op && is_key_load && slot_ok;
    assign key_addr    = is_key_load ? slot_ext[KEY_AW-1:0] : pos_sel;

    srksc_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .re    (ctl.mem_op),
        .addr  (req_reg.data_byte),
        .wdata (req_reg.map_value),
        .rdata (map_rdata)
    );

    srksc_ram #(
        .WIDTH (7),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .re    (ctl.mem_op),
        .addr  (key_addr),
        .wdata (req_reg.key_value),
        .rdata (key_rdata)
    );

    assign c_sel  = loaded_reg[req_reg.data_byte] ? map_rdata : req_reg.data_byte;
    assign in_rng = (range_low_reg <= range_high_reg) && (c_sel >= range_low_reg) &&
                    (c_sel <= range_high_reg);
    assign sum_w  = {1'b0, c_sel - range_low_reg} + {2'b00, key_rdata};
    assign span   = {1'b0, range_high_reg} - {1'b0, range_low_reg} + 9'd1;
    assign trial  = {rem_reg[7:0], div_reg[8]};
    assign rem_next = (trial >= span) ? (trial - span) : trial;

    assign out_full = out_valid_reg && !out_ready;
    assign fire     = ctl.emit && !out_full;

    always_comb
    begin
        out_data_next.out_byte = used_reg ? (rem_reg[7:0] + range_low_reg) : c_reg;
        out_data_next.key_used = used_reg;
        out_data_next.last_out = req_reg.last_in;
        if (req_reg.last_in)
        begin
            key_pos_next = '0;
        end
        else if (used_reg)
        begin
            key_pos_next = pos_adv;
        end
        else
        begin
            key_pos_next = key_pos_reg;
        end
    end

    always_comb
    begin
        stat.not_encrypt = req_reg.req_type != srksc_pkg::REQ_ENCRYPT;
        stat.out_range   = !in_rng;
        stat.div_busy    = cnt_reg != '0;
        stat.out_full    = out_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= 8'd0;
            range_high_reg <= 8'd255;
            key_length_reg <= srksc_pkg::KEY_LEN_W'(1);
            loaded_reg     <= '0;
            key_pos_reg    <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    srksc_pkg::CFG_RANGE_LOW:  range_low_reg  <= cfg_data[7:0];
                    srksc_pkg::CFG_RANGE_HIGH: range_high_reg <= cfg_data[7:0];
                    srksc_pkg::CFG_KEY_LENGTH: key_length_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (map_we)
            begin
                loaded_reg[req_reg.data_byte] <= 1'b1;
            end
            if (ctl.ld_sub)
            begin
                cnt_reg <= srksc_pkg::CNT_W'(srksc_pkg::DIV_STEPS - 1);
            end
            else if (ctl.div_step && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - srksc_pkg::CNT_W'(1);
            end
            if (fire)
            begin
                key_pos_reg   <= key_pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_in && in_valid)
        begin
            req_reg <= in_data;
        end
        if (ctl.mem_op)
        begin
            pos_reg <= pos_sel;
        end
        if (ctl.ld_sub)
        begin
            c_reg    <= c_sel;
            used_reg <= in_rng;
            div_reg  <= sum_w;
            rem_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            div_reg <= {div_reg[7:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/srksc_seq.sv @@
// Microcode sequencer: step counter, control table lookup and branch conditions.
module srksc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  srksc_pkg::stat_t stat,
    output srksc_pkg::ctl_t  ctl
);

    srksc_pkg::step_t  step_reg;
    srksc_pkg::step_t  step_next;
    srksc_pkg::uword_t uw;

    function automatic logic cond_hit(input srksc_pkg::cond_t c, input srksc_pkg::stat_t s,
                                      input logic v);
        logic hit;
        begin
            unique case (c)
                srksc_pkg::COND_NEVER:       hit = 1'b0;
                srksc_pkg::COND_ALWAYS:      hit = 1'b1;
                srksc_pkg::COND_NO_INPUT:    hit = !v;
                srksc_pkg::COND_NOT_ENCRYPT: hit = s.not_encrypt;
                srksc_pkg::COND_OUT_RANGE:   hit = s.out_range;
                srksc_pkg::COND_DIV_BUSY:    hit = s.div_busy;
                srksc_pkg::COND_OUT_FULL:    hit = s.out_full;
                default:                     hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    always_comb
    begin
        uw  = srksc_pkg::ucode(step_reg);
        ctl = uw.act;
        if (cond_hit(uw.wait_on, stat, in_valid))
        begin
            step_next = step_reg;
        end
        else if (cond_hit(uw.br_on, stat, in_valid))
        begin
            step_next = uw.br_to;
        end
        else
        begin
            step_next = step_reg + srksc_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= srksc_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/core/substitution_running_key_shift_cipher.sv @@
// Top level of the substitution running-key shift cipher.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   in_data (in_payload_t)
//  out       output     out_valid / out_ready out_data (out_payload_t)
//  cfg       input      cfg_we                cfg_index, cfg_data
//
// A load or an ignored request runs the FETCH and DECODE steps; an encrypt outside
// the range adds MAP and EMIT; a shift adds the datapath's nine-step remainder loop.
// The output register holds a finished byte while the next transaction is fetched;
// the emit step waits only when that register is still full.
// Reset clears the control state and the map's loaded bits at once; no clearing pass.
`include "substitution_running_key_shift_cipher_macros.svh"

module substitution_running_key_shift_cipher #(
    parameter int KEY_DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srksc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srksc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  srksc_pkg::in_payload_t           in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output srksc_pkg::out_payload_t          out_data
);

    srksc_pkg::ctl_t  ctl;
    srksc_pkg::stat_t stat;

    srksc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    srksc_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = ctl.ld_in;

    // A transaction is processed alone: no second one is taken right after.
    `SRKSC_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    // A new result appears only from the emit step.
    `SRKSC_ASSERT_SAME(a_out_from_emit, clk, rst_n, $rose(out_valid), $past(ctl.emit))
    // The emit step holds while the output register is still occupied.
    `SRKSC_ASSERT_NEXT(a_emit_waits, clk, rst_n, ctl.emit && stat.out_full, ctl.emit)

endmodule
